### src/assert_macros.svh
// Assertion shorthands for the RTL; triangle_grid_binning_unit includes them.
// Both expect a signal named clk in the including module; TGB_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define TGB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define TGB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/tgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tgb_pkg;

    localparam int GRID_X   = 16;
    localparam int GRID_Y   = 16;
    localparam int GRID_Z   = 16;
    localparam int MAX_SPAN = 4;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int ID_W    = 16;
    localparam int CELL_W  = 4;
    localparam int SHIFT_W = 4;

    localparam int XW = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int YW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;

    // The occupancy store holds one row per (x, y) pair, one bit per z cell.
    localparam int ROWS  = GRID_X * GRID_Y;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam int IN_DATA_W  = ID_W + 9 * COORD_W;
    localparam int IN_USER_W  = 1;
    localparam int OUT_FLD_W  = 3 * CELL_W + ID_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;
    localparam int OUT_USER_W = 3;

    localparam int USER_SHARED_BIT  = 0;
    localparam int USER_VALID_BIT   = 1;
    localparam int USER_DROPPED_BIT = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic [SHIFT_W-1:0] CELL_SHIFT_RESET = SHIFT_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X   = 2'd0,
        CFG_ORIGIN_Y   = 2'd1,
        CFG_ORIGIN_Z   = 2'd2,
        CFG_CELL_SHIFT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              rd_en;
        logic [ROW_W-1:0]  rd_addr;
        logic              wr_en;
        logic [ROW_W-1:0]  wr_addr;
        logic [GRID_Z-1:0] wr_data;
    } ram_req_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] lo;
        logic signed [DIFF_W-1:0] hi;
    } span_raw_t;

endpackage

`default_nettype wire

### src/triangle_grid_binning_unit.sv
// Add request: box (S_BOX) and clip (S_CLIP) work, then for each covered cell an
// occupancy row read, then a write back with its result, held while the output is full.
// Clear request: one occupancy row per cycle, all ROWS (256) rows, then the ack.
// Reset is asynchronous, active low; afterwards the same row-by-row pass empties
// the grid with s_axis_tready low, while configuration writes are taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module triangle_grid_binning_unit
    import tgb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tri_id, ax, ay, az, bx, by, bz, cx, cy, cz (16 bits each, lowest first)
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // cell_x[3:0], cell_y[7:4], cell_z[11:8], owner_id[27:12], zero fill
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // shared, cell_valid, dropped
    output logic [OUT_USER_W-1:0]      m_axis_tuser,
    // last
    output logic                       m_axis_tlast
);

    typedef enum logic [8:0] {
        S_INIT    = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_BOX     = 9'b000000100,
        S_CLIP    = 9'b000001000,
        S_RD      = 9'b000010000,
        S_MOD     = 9'b000100000,
        S_EMPTY   = 9'b001000000,
        S_CLR     = 9'b010000000,
        S_CLRDONE = 9'b100000000
    } state_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] lo;
        logic signed [DIFF_W-1:0] hi;
        logic                     drop;
        logic                     empty;
    } axis_t;

    function automatic axis_t clip_axis(span_raw_t r, logic signed [DIFF_W-1:0] gmax);
        axis_t                    res;
        logic signed [DIFF_W-1:0] l;
        logic signed [DIFF_W-1:0] h;
        l = r.lo;
        h = r.hi;
        res.drop  = 1'b0;
        res.empty = 1'b0;
        if (l < 0)
        begin
            l = '0;
            res.drop = 1'b1;
        end
        if (h > gmax)
        begin
            h = gmax;
            res.drop = 1'b1;
        end
        if (l > h)
        begin
            res.drop  = 1'b1;
            res.empty = 1'b1;
        end
        else if (h - l >= DIFF_W'(MAX_SPAN))
        begin
            h = l + DIFF_W'(MAX_SPAN - 1);
            res.drop = 1'b1;
        end
        res.lo = l;
        res.hi = h;
        return res;
    endfunction

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic [ROW_W-1:0] sweep_reg, sweep_next;

    logic signed [COORD_W-1:0] origin_x_reg, origin_x_next;
    logic signed [COORD_W-1:0] origin_y_reg, origin_y_next;
    logic signed [COORD_W-1:0] origin_z_reg, origin_z_next;
    logic        [SHIFT_W-1:0] cell_shift_reg, cell_shift_next;

    logic [XW-1:0] x_reg, x_next, lx_reg, lx_next, hx_reg, hx_next;
    logic [YW-1:0] y_reg, y_next, ly_reg, ly_next, hy_reg, hy_next;
    logic [ZW-1:0] z_reg, z_next, lz_reg, lz_next, hz_reg, hz_next;
    logic          drop_reg, drop_next;

    logic [IN_DATA_W-1:0]  in_data_reg, in_data_next;
    span_raw_t             span_x_reg, span_y_reg, span_z_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg, out_user_next;
    logic                  out_last_reg, out_last_next;

    span_raw_t span_x, span_y, span_z;
    axis_t     clip_x, clip_y, clip_z;

    ram_req_t          ram_req;
    logic [GRID_Z-1:0] ram_rd_data;

    logic          out_load;
    logic          cell_last;
    logic          was_set;
    logic [ID_W-1:0] tri_id;
    logic [ROW_W-1:0] cur_row;

    assign tri_id  = in_data_reg[ID_W-1:0];
    assign cur_row = ROW_W'(x_reg) * ROW_W'(GRID_Y) + ROW_W'(y_reg);

    tgb_axis_span u_span_x (
        .a     ($signed(in_data_reg[31:16])),
        .b     ($signed(in_data_reg[79:64])),
        .c     ($signed(in_data_reg[127:112])),
        .org   (origin_x_reg),
        .shift (cell_shift_reg),
        .span  (span_x)
    );

    tgb_axis_span u_span_y (
        .a     ($signed(in_data_reg[47:32])),
        .b     ($signed(in_data_reg[95:80])),
        .c     ($signed(in_data_reg[143:128])),
        .org   (origin_y_reg),
        .shift (cell_shift_reg),
        .span  (span_y)
    );

    tgb_axis_span u_span_z (
        .a     ($signed(in_data_reg[63:48])),
        .b     ($signed(in_data_reg[111:96])),
        .c     ($signed(in_data_reg[159:144])),
        .org   (origin_z_reg),
        .shift (cell_shift_reg),
        .span  (span_z)
    );

    tgb_occ_ram u_occ_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    assign out_load  = !out_valid_reg || m_axis_tready;
    assign cell_last = (x_reg == hx_reg) && (y_reg == hy_reg) && (z_reg == hz_reg);
    assign was_set   = ram_rd_data[z_reg];

    always_comb
    begin
        clip_x = clip_axis(span_x_reg, DIFF_W'(GRID_X - 1));
        clip_y = clip_axis(span_y_reg, DIFF_W'(GRID_Y - 1));
        clip_z = clip_axis(span_z_reg, DIFF_W'(GRID_Z - 1));
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        sweep_next      = sweep_reg;
        origin_x_next   = origin_x_reg;
        origin_y_next   = origin_y_reg;
        origin_z_next   = origin_z_reg;
        cell_shift_next = cell_shift_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        lx_next         = lx_reg;
        ly_next         = ly_reg;
        lz_next         = lz_reg;
        hx_next         = hx_reg;
        hy_next         = hy_reg;
        hz_next         = hz_reg;
        drop_next       = drop_reg;
        in_data_next    = in_data_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        out_last_next   = out_last_reg;

        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = cur_row;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = cur_row;
        ram_req.wr_data = ram_rd_data | (GRID_Z'(1) << z_reg);

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ORIGIN_X:   origin_x_next   = $signed(cfg_data[COORD_W-1:0]);
                CFG_ORIGIN_Y:   origin_y_next   = $signed(cfg_data[COORD_W-1:0]);
                CFG_ORIGIN_Z:   origin_z_next   = $signed(cfg_data[COORD_W-1:0]);
                CFG_CELL_SHIFT: cell_shift_next = cfg_data[SHIFT_W-1:0];
                default:        ;
            endcase
        end

        case (state_reg)
            S_INIT, S_CLR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = sweep_reg;
                ram_req.wr_data = '0;
                sweep_next      = sweep_reg + ROW_W'(1);
                if (sweep_reg == ROW_W'(ROWS - 1))
                begin
                    sweep_next = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_CLRDONE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_data_next = s_axis_tdata;
                    sweep_next   = '0;
                    state_next   = (s_axis_tuser[0] == FUNC_CLEAR) ? S_CLR : S_BOX;
                end
            end
            S_BOX:
            begin
                state_next = S_CLIP;
            end
            S_CLIP:
            begin
                drop_next = clip_x.drop || clip_y.drop || clip_z.drop;
                lx_next   = XW'(clip_x.lo);
                hx_next   = XW'(clip_x.hi);
                ly_next   = YW'(clip_y.lo);
                hy_next   = YW'(clip_y.hi);
                lz_next   = ZW'(clip_z.lo);
                hz_next   = ZW'(clip_z.hi);
                x_next    = XW'(clip_x.lo);
                y_next    = YW'(clip_y.lo);
                z_next    = ZW'(clip_z.lo);
                if (clip_x.empty || clip_y.empty || clip_z.empty)
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                ram_req.rd_en = 1'b1;
                state_next    = S_MOD;
            end
            S_MOD:
            begin
                // The row read in S_RD stays on the read port until the write here,
                // and the next read comes in the cycle after it, so no access overlaps.
                if (out_load)
                begin
                    ram_req.wr_en  = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = {{OUT_PAD_W{1'b0}}, tri_id,
                                      CELL_W'(z_reg), CELL_W'(y_reg), CELL_W'(x_reg)};
                    out_user_next  = {drop_reg, 1'b1, was_set};
                    out_last_next  = cell_last;
                    if (z_reg == hz_reg)
                    begin
                        z_next = lz_reg;
                        if (y_reg == hy_reg)
                        begin
                            y_next = ly_reg;
                            x_next = x_reg + XW'(1);
                        end
                        else
                        begin
                            y_next = y_reg + YW'(1);
                        end
                    end
                    else
                    begin
                        z_next = z_reg + ZW'(1);
                    end
                    state_next = cell_last ? S_IDLE : S_RD;
                end
            end
            S_EMPTY:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{OUT_PAD_W{1'b0}}, tri_id, {(3 * CELL_W){1'b0}}};
                    out_user_next  = '0;
                    out_user_next[USER_DROPPED_BIT] = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CLRDONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_user_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            out_valid_reg  <= 1'b0;
            sweep_reg      <= '0;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            origin_z_reg   <= '0;
            cell_shift_reg <= CELL_SHIFT_RESET;
            x_reg          <= '0;
            y_reg          <= '0;
            z_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            sweep_reg      <= sweep_next;
            origin_x_reg   <= origin_x_next;
            origin_y_reg   <= origin_y_next;
            origin_z_reg   <= origin_z_next;
            cell_shift_reg <= cell_shift_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            z_reg          <= z_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg  <= in_data_next;
        span_x_reg   <= span_x;
        span_y_reg   <= span_y;
        span_z_reg   <= span_z;
        lx_reg       <= lx_next;
        ly_reg       <= ly_next;
        lz_reg       <= lz_next;
        hx_reg       <= hx_next;
        hy_reg       <= hy_next;
        hz_reg       <= hz_next;
        drop_reg     <= drop_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    `TGB_ASSERT_ALWAYS(a_reset_blocks_input, !rst_n |-> !s_axis_tready, "input open during reset")
    `TGB_ASSERT(a_one_request_at_a_time, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second request taken while busy")
    `TGB_ASSERT(a_ram_no_overlap, !(ram_req.rd_en && ram_req.wr_en), "occupancy read and write in one cycle")
    `TGB_ASSERT(a_mark_sets_bit, (state_reg == S_MOD && ram_req.wr_en) |-> ram_req.wr_data[z_reg], "cell write does not set its occupied bit")
    `TGB_ASSERT(a_no_cell_is_last, (m_axis_tvalid && !m_axis_tuser[USER_VALID_BIT]) |-> m_axis_tlast, "result without a cell is not last")

endmodule

`default_nettype wire

### src/tgb_occ_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tgb_occ_ram
    import tgb_pkg::*;
(
    input  wire logic              clk,
    input  wire ram_req_t          req,
    output logic      [GRID_Z-1:0] rd_data
);

    logic [GRID_Z-1:0] mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

### src/tgb_axis_span.sv
`timescale 1ns / 1ps
`default_nettype none

module tgb_axis_span
    import tgb_pkg::*;
(
    input  wire logic signed [COORD_W-1:0] a,
    input  wire logic signed [COORD_W-1:0] b,
    input  wire logic signed [COORD_W-1:0] c,
    input  wire logic signed [COORD_W-1:0] org,
    input  wire logic        [SHIFT_W-1:0] shift,
    output span_raw_t                      span
);

    logic signed [COORD_W-1:0] mn;
    logic signed [COORD_W-1:0] mx;
    logic signed [DIFF_W-1:0]  d_lo;
    logic signed [DIFF_W-1:0]  d_hi;

    always_comb
    begin
        mn = a;
        if (b < mn)
        begin
            mn = b;
        end
        if (c < mn)
        begin
            mn = c;
        end
        mx = a;
        if (b > mx)
        begin
            mx = b;
        end
        if (c > mx)
        begin
            mx = c;
        end
        // The difference needs one bit more than the coordinates.
        d_lo = DIFF_W'(mn) - DIFF_W'(org);
        d_hi = DIFF_W'(mx) - DIFF_W'(org);
        // An arithmetic shift of a signed value is the floor of the quotient.
        span.lo = d_lo >>> shift;
        span.hi = d_hi >>> shift;
    end

endmodule

`default_nettype wire
